/* rtl/core/rltc_pkg.sv */
// ----------------------------------------------------------------------------
// rltc_pkg
// Shared types and constants for the ordering table clear DMA channel.
// ----------------------------------------------------------------------------
`default_nettype none

package rltc_pkg;

  localparam int ADDR_BITS  = 24;
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int MEM_W      = 24;
  localparam int DATA_W     = 32;

  localparam logic [DATA_W-1:0] MADR_HIGH  = 32'hFF00_0000;
  localparam logic [DATA_W-1:0] CHCR_FIXED = 32'h0000_0002;
  localparam logic [MEM_W-1:0]  END_MARK   = 24'hFF_FFFF;
  localparam int BIT_START   = 24;
  localparam int BIT_TRIGGER = 28;
  localparam int BIT_SNOOP   = 30;
  localparam int STEP        = 4;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    OFF_MADR = 4'h0,
    OFF_BCR  = 4'h4,
    OFF_CHCR = 4'h8
  } reg_off_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_MEMWR = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] read_data;
    logic [MEM_W-1:0]  mem_addr;
    logic [MEM_W-1:0]  mem_data;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/rltc_ifs.sv */
// ----------------------------------------------------------------------------
// rltc_ifs
// Valid/ready channel interfaces for the request and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

interface rltc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  reg_offset;
  logic [31:0] write_data;

  modport source (output valid, output func, output reg_offset, output write_data,
                  input ready);
  modport sink   (input valid, input func, input reg_offset, input write_data,
                  output ready);
endinterface

interface rltc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] read_data;
  logic [23:0] mem_addr;
  logic [23:0] mem_data;
  logic        last;

  modport source (output valid, output kind, output read_data, output mem_addr,
                  output mem_data, output last, input ready);
  modport sink   (input valid, input kind, input read_data, input mem_addr,
                  input mem_data, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/rltc_core.sv */
// ----------------------------------------------------------------------------
// rltc_core
// Channel registers, transfer sequencer and result formation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rltc_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [1:0]            func,
  input  wire logic [3:0]            reg_offset,
  input  wire logic [31:0]           write_data,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,
  output      logic                  res_valid,
  output      rltc_pkg::res_t        res
);

  logic                            enable_r;
  logic [rltc_pkg::MEM_W-1:0]      base_r, base_nxt;
  logic [rltc_pkg::DATA_W-1:0]     bcw_r, bcw_nxt;
  logic                            start_r, start_nxt;
  logic                            trig_r, trig_nxt;
  logic                            snoop_r, snoop_nxt;
  logic                            busy_r, busy_nxt;
  logic [rltc_pkg::ADDR_BITS-1:0]  cur_r, cur_nxt;
  logic [rltc_pkg::CNT_W-1:0]      left_r, left_nxt;

  logic [rltc_pkg::ADDR_BITS-1:0]  cur_dec;
  logic [rltc_pkg::COUNT_BITS-1:0] cnt_field;
  logic [rltc_pkg::CNT_W-1:0]      cnt_load;
  logic [rltc_pkg::DATA_W-1:0]     rd_val;
  logic                            fin;

  assign cur_dec   = cur_r - rltc_pkg::ADDR_BITS'(rltc_pkg::STEP);
  assign cnt_field = bcw_r[rltc_pkg::COUNT_BITS-1:0];
  // a count of zero means the full range
  assign cnt_load  = (cnt_field == '0) ? (rltc_pkg::CNT_W'(1) << rltc_pkg::COUNT_BITS)
                                       : rltc_pkg::CNT_W'(cnt_field);
  assign fin       = (left_r <= rltc_pkg::CNT_W'(1));

  always_comb begin
    case (rltc_pkg::reg_off_t'(reg_offset))
      rltc_pkg::OFF_MADR: rd_val = rltc_pkg::MADR_HIGH | rltc_pkg::DATA_W'(base_r);
      rltc_pkg::OFF_BCR:  rd_val = bcw_r;
      rltc_pkg::OFF_CHCR: rd_val = rltc_pkg::CHCR_FIXED
                                 | (rltc_pkg::DATA_W'(start_r) << rltc_pkg::BIT_START)
                                 | (rltc_pkg::DATA_W'(trig_r)  << rltc_pkg::BIT_TRIGGER)
                                 | (rltc_pkg::DATA_W'(snoop_r) << rltc_pkg::BIT_SNOOP);
      default:            rd_val = '0;
    endcase
  end

  always_comb begin
    base_nxt  = base_r;
    bcw_nxt   = bcw_r;
    start_nxt = start_r;
    trig_nxt  = trig_r;
    snoop_nxt = snoop_r;
    busy_nxt  = busy_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    res_valid = 1'b0;
    res       = '0;
    if (accept) begin
      case (rltc_pkg::func_t'(func))
        rltc_pkg::FUNC_READ: begin
          res_valid     = 1'b1;
          res.kind      = rltc_pkg::KIND_READ;
          res.read_data = rd_val;
        end
        rltc_pkg::FUNC_WRITE: begin
          if (!busy_r) begin
            case (rltc_pkg::reg_off_t'(reg_offset))
              rltc_pkg::OFF_MADR: base_nxt = write_data[rltc_pkg::MEM_W-1:0];
              rltc_pkg::OFF_BCR:  bcw_nxt  = write_data;
              rltc_pkg::OFF_CHCR: begin
                start_nxt = write_data[rltc_pkg::BIT_START];
                trig_nxt  = write_data[rltc_pkg::BIT_TRIGGER];
                snoop_nxt = write_data[rltc_pkg::BIT_SNOOP];
                if (write_data[rltc_pkg::BIT_START] && write_data[rltc_pkg::BIT_TRIGGER]
                    && enable_r) begin
                  left_nxt = cnt_load;
                  cur_nxt  = rltc_pkg::ADDR_BITS'(base_r);
                  busy_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        rltc_pkg::FUNC_TICK: begin
          if (busy_r) begin
            res_valid    = 1'b1;
            res.kind     = rltc_pkg::KIND_MEMWR;
            res.mem_addr = rltc_pkg::MEM_W'(cur_r);
            res.mem_data = fin ? rltc_pkg::END_MARK : rltc_pkg::MEM_W'(cur_dec);
            res.last     = fin;
            cur_nxt      = cur_dec;
            if (fin) begin
              left_nxt  = '0;
              busy_nxt  = 1'b0;
              start_nxt = 1'b0;
              trig_nxt  = 1'b0;
            end else begin
              left_nxt  = left_r - rltc_pkg::CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      base_r   <= '0;
      bcw_r    <= '0;
      start_r  <= 1'b0;
      trig_r   <= 1'b0;
      snoop_r  <= 1'b0;
      busy_r   <= 1'b0;
      cur_r    <= '0;
      left_r   <= '0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      base_r  <= base_nxt;
      bcw_r   <= bcw_nxt;
      start_r <= start_nxt;
      trig_r  <= trig_nxt;
      snoop_r <= snoop_nxt;
      busy_r  <= busy_nxt;
      cur_r   <= cur_nxt;
      left_r  <= left_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (left_r != '0))
    else $error("busy with no words left");
  a_idle_no_words: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (left_r == '0))
    else $error("idle with words left");
  a_launch_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> (start_r && trig_r && enable_r))
    else $error("transfer started without start, trigger and enable");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (!start_r && !trig_r))
    else $error("start or trigger left set after transfer");
`endif

endmodule

`default_nettype wire

/* rtl/core/rltc_out_reg.sv */
// ----------------------------------------------------------------------------
// rltc_out_reg
// Result register; holds one result and refills in the cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rltc_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire rltc_pkg::res_t res_in,
  input  wire logic           out_ready,
  output      logic           out_valid,
  output      logic           can_take,
  output      rltc_pkg::res_t res_out
);

  logic           valid_r, valid_nxt;
  rltc_pkg::res_t data_r;

  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !load)
    else $error("result overwritten before taken");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_ready && !load) |=> !valid_r)
    else $error("result held after transaction");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

/* rtl/core/reverse_link_table_clear_dma_top.sv */
// Latency: a result is presented the cycle after its request transaction.
// One request per cycle unless out_ch stalls; the result register refills as it drains.
// A tick while busy issues one table write, so a transfer of N words takes N ticks.
// Reset (rst_n low, synchronous) clears all channel registers and the result valid.
// ----------------------------------------------------------------------------
// reverse_link_table_clear_dma_top
// Ordering table clear DMA channel: bus registers and linked-table writer.
// ----------------------------------------------------------------------------
`default_nettype none

module reverse_link_table_clear_dma_top (
  input  wire logic clk,
  input  wire logic rst_n,
  rltc_in_if.sink   in_ch,
  rltc_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  logic           accept;
  logic           can_take;
  logic           res_valid;
  rltc_pkg::res_t res;
  rltc_pkg::res_t res_q;

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  rltc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .func       (in_ch.func),
    .reg_offset (in_ch.reg_offset),
    .write_data (in_ch.write_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  rltc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_take  (can_take),
    .res_out   (res_q)
  );

  assign out_ch.kind      = res_q.kind;
  assign out_ch.read_data = res_q.read_data;
  assign out_ch.mem_addr  = res_q.mem_addr;
  assign out_ch.mem_data  = res_q.mem_data;
  assign out_ch.last      = res_q.last;

endmodule

`default_nettype wire

/* tb/rltc_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rltc_table_checker
// Watches the request and result channels and the enable port of the table
// clear channel. It keeps its own copy of the channel registers, works out
// the reply to each accepted request and compares every result field.
// ----------------------------------------------------------------------------

module rltc_table_checker (
  input  logic clk,
  input  logic rst_n,
  rltc_in_if   in_ch,
  rltc_out_if  out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   pending,
  output int   n_checked,
  output int   n_table_writes,
  output int   n_transfers
);
  import rltc_pkg::*;

  res_t replies_due[$];

  logic                 chan_enable;
  logic [MEM_W-1:0]     base_addr;
  logic [DATA_W-1:0]    bcr_word;
  logic                 start_b;
  logic                 trig_b;
  logic                 snoop_b;
  logic                 busy;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [CNT_W-1:0]     words_left;

  initial begin
    fail_count     = 0;
    pending        = 0;
    n_checked      = 0;
    n_table_writes = 0;
    n_transfers    = 0;
  end

  // only the first few are printed, all are counted
  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("[%0t] CHECK FAILED: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [DATA_W-1:0] reg_value(input logic [3:0] off);
    case (off)
      OFF_MADR: return MADR_HIGH | {8'h00, base_addr};
      OFF_BCR:  return bcr_word;
      OFF_CHCR: return CHCR_FIXED | (DATA_W'(start_b) << BIT_START) |
                       (DATA_W'(trig_b) << BIT_TRIGGER) | (DATA_W'(snoop_b) << BIT_SNOOP);
      default:  return '0;
    endcase
  endfunction

  task automatic predict_channel(input logic [1:0] f, input logic [3:0] off,
                                 input logic [31:0] d);
    res_t r;
    logic fin;
    r = '0;
    case (f)
      FUNC_READ: begin
        r.kind      = KIND_READ;
        r.read_data = reg_value(off);
        replies_due.push_back(r);
      end
      FUNC_WRITE: begin
        if (!busy) begin
          case (off)
            OFF_MADR: base_addr = d[MEM_W-1:0];
            OFF_BCR:  bcr_word = d;
            OFF_CHCR: begin
              start_b = d[BIT_START];
              trig_b  = d[BIT_TRIGGER];
              snoop_b = d[BIT_SNOOP];
              if (start_b && trig_b && chan_enable) begin
                // a zero count means a full 2^COUNT_BITS words
                words_left = (bcr_word[COUNT_BITS-1:0] == '0) ? (CNT_W'(1) << COUNT_BITS) :
                             CNT_W'(bcr_word[COUNT_BITS-1:0]);
                cur_addr   = base_addr;
                busy       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FUNC_TICK: begin
        if (busy) begin
          fin        = (words_left <= CNT_W'(1));
          r.kind     = KIND_MEMWR;
          r.mem_addr = cur_addr;
          r.mem_data = fin ? END_MARK : cur_addr - ADDR_BITS'(STEP);
          r.last     = fin;
          replies_due.push_back(r);
          cur_addr = cur_addr - ADDR_BITS'(STEP);
          if (fin) begin
            words_left = '0;
            busy       = 1'b0;
            start_b    = 1'b0;
            trig_b     = 1'b0;
          end else begin
            words_left = words_left - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_reply();
    res_t want;
    if (replies_due.size() == 0) begin
      report_mismatch("result transaction with nothing outstanding");
    end else begin
      want = replies_due.pop_front();
      n_checked++;
      if (want.kind == KIND_MEMWR) n_table_writes++;
      if (want.kind == KIND_MEMWR && want.last) n_transfers++;
      if (out_ch.kind !== want.kind)
        report_mismatch($sformatf("kind got %b expected %b", out_ch.kind, want.kind));
      if (out_ch.read_data !== want.read_data)
        report_mismatch($sformatf("read_data got %h expected %h",
                                  out_ch.read_data, want.read_data));
      if (out_ch.mem_addr !== want.mem_addr)
        report_mismatch($sformatf("mem_addr got %h expected %h",
                                  out_ch.mem_addr, want.mem_addr));
      if (out_ch.mem_data !== want.mem_data)
        report_mismatch($sformatf("mem_data got %h expected %h",
                                  out_ch.mem_data, want.mem_data));
      if (out_ch.last !== want.last)
        report_mismatch($sformatf("last got %b expected %b", out_ch.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_enable = 1'b0;
      base_addr   = '0;
      bcr_word    = '0;
      start_b     = 1'b0;
      trig_b      = 1'b0;
      snoop_b     = 1'b0;
      busy        = 1'b0;
      cur_addr    = '0;
      words_left  = '0;
      replies_due.delete();
    end else begin
      // a result never belongs to the request taken at the same edge
      if (out_ch.valid && out_ch.ready) check_reply();
      if (in_ch.valid && in_ch.ready)
        predict_channel(in_ch.func, in_ch.reg_offset, in_ch.write_data);
      // the enable seen by a request is the one held before its edge
      if (cfg_we) chan_enable = cfg_wdata;
    end
    pending = replies_due.size();
  end

endmodule

/* tb/reverse_link_table_clear_dma_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reverse_link_table_clear_dma_top_tb
// Drives register reads, writes and ticks into the table clear channel under
// several idle and stall patterns and enable settings; the checker beside the
// block predicts and compares every result transaction.
// ----------------------------------------------------------------------------

module reverse_link_table_clear_dma_top_tb;
  import rltc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_PHASES    = 5;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  int idle_pct;
  int stall_pct;
  int sent;
  int cycles;
  int fail_count;
  int pending;
  int n_checked;
  int n_table_writes;
  int n_transfers;

  int idle_by_phase[N_PHASES]   = '{0, 68, 0, 0, 7};
  int stall_by_phase[N_PHASES]  = '{0, 0, 68, 68, 7};
  int enable_by_phase[N_PHASES] = '{1, 1, 0, 1, 1};
  int items_by_phase[N_PHASES]  = '{290, 290, 100, 290, 260};

  rltc_in_if  in_ch ();
  rltc_out_if out_ch ();

  reverse_link_table_clear_dma_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rltc_table_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .n_checked      (n_checked),
    .n_table_writes (n_table_writes),
    .n_transfers    (n_transfers)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("reverse_link_table_clear_dma_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // one request transaction; called and returns at a falling edge
  task automatic send(input logic [1:0] f, input logic [3:0] off, input logic [31:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.reg_offset <= off;
    in_ch.write_data <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_noise();
    send(2'($urandom_range(3)), 4'($urandom_range(15)), $urandom);
  endtask

  // hold off until every expected result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_enable(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // program the channel, try to launch it, and tick it through with stray transactions mixed in
  task automatic table_clear(input int words);
    logic [31:0] madr;
    logic [31:0] ctl;
    madr = $urandom;
    if ($urandom_range(7) == 0) madr[23:6] = '0;  // close to zero, so the addresses can wrap
    ctl = $urandom;
    if ($urandom_range(9) != 0) begin
      ctl[BIT_START]   = 1'b1;
      ctl[BIT_TRIGGER] = 1'b1;
    end
    send(FUNC_WRITE, OFF_MADR, madr);
    send(FUNC_WRITE, OFF_BCR, ($urandom & 32'hFFFF_0000) | 32'(words[15:0]));
    if ($urandom_range(2) == 0) send(FUNC_READ, 4'($urandom_range(15)), $urandom);
    send(FUNC_WRITE, OFF_CHCR, ctl);
    for (int i = 0; i < words + int'($urandom_range(2)); i++) begin
      if ($urandom_range(4) == 0) send_noise();
      send(FUNC_TICK, 4'($urandom_range(15)), $urandom);
    end
  endtask

  initial begin
    int phase_start;
    int words;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_READ;
    in_ch.reg_offset = OFF_MADR;
    in_ch.write_data = '0;
    out_ch.ready     = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    sent             = 0;
    cycles           = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, unmapped offsets, all-ones writes with the channel disabled
    send(FUNC_READ, OFF_MADR, '0);
    send(FUNC_READ, OFF_BCR, '0);
    send(FUNC_READ, OFF_CHCR, '0);
    send(FUNC_READ, 4'hF, 32'hFFFF_FFFF);
    send(FUNC_WRITE, OFF_MADR, 32'hFFFF_FFFF);
    send(FUNC_WRITE, OFF_BCR, 32'hFFFF_FFFF);
    send(FUNC_WRITE, OFF_CHCR, 32'hFFFF_FFFF);
    send(FUNC_WRITE, 4'hC, 32'hFFFF_FFFF);
    send(FUNC_READ, OFF_MADR, '0);
    send(FUNC_READ, OFF_BCR, '0);
    send(FUNC_READ, OFF_CHCR, '0);
    send(FUNC_TICK, 4'hF, 32'hFFFF_FFFF);
    send(2'd3, 4'hF, 32'hFFFF_FFFF);
    drain();
    set_enable(1'b1);
    // enabling afterwards must not launch the stored start
    send(FUNC_TICK, OFF_MADR, '0);
    // four words from 0x8 down, wrapping below zero
    send(FUNC_WRITE, OFF_MADR, 32'h0000_0008);
    send(FUNC_WRITE, OFF_BCR, 32'h0000_0004);
    send(FUNC_WRITE, OFF_CHCR, 32'h1100_0000);
    send(FUNC_WRITE, OFF_MADR, 32'h0012_3450);  // ignored while busy
    send(FUNC_READ, OFF_CHCR, '0);
    repeat (5) send(FUNC_TICK, OFF_MADR, '0);
    send(FUNC_READ, OFF_CHCR, '0);
    // single-word transfer with snoop set
    send(FUNC_WRITE, OFF_BCR, 32'h0000_0001);
    send(FUNC_WRITE, OFF_CHCR, 32'h5100_0000);
    send(FUNC_TICK, OFF_CHCR, '0);
    send(FUNC_READ, OFF_MADR, '0);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_enable(enable_by_phase[p][0]);
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      phase_start = sent;
      while (sent - phase_start < items_by_phase[p]) begin
        case ($urandom_range(9))
          0: repeat ($urandom_range(1, 4)) send_noise();
          1: if ($urandom_range(3) == 0) drain();
          default: begin
            words = ($urandom_range(7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
            table_clear(words);
          end
        endcase
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    // zero count: a full-size table, so none of the first writes is the last;
    // it starts just above zero so the addresses wrap, and is left running
    send(FUNC_WRITE, OFF_MADR, 32'hA500_0010);
    send(FUNC_WRITE, OFF_BCR, 32'h5A5A_0000);
    send(FUNC_WRITE, OFF_CHCR, 32'h1000_0000 | (32'h1 << BIT_START));
    repeat (40) send(FUNC_TICK, 4'($urandom_range(15)), $urandom);
    send(FUNC_READ, OFF_CHCR, '0);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Run covered %0d bus transactions over %0d phases of idling and enable settings.",
             sent, N_PHASES);
    $display("Checked %0d results: %0d table writes closing %0d transfers, %0d register reads.",
             n_checked, n_table_writes, n_transfers, n_checked - n_table_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("reverse_link_table_clear_dma_top: match");
    end else begin
      $display("reverse_link_table_clear_dma_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rltc_pkg.sv
rtl/core/rltc_ifs.sv
rtl/core/rltc_core.sv
rtl/core/rltc_out_reg.sv
rtl/core/reverse_link_table_clear_dma_top.sv
tb/rltc_table_checker.sv
tb/reverse_link_table_clear_dma_top_tb.sv
